@@ src/gnmc_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the neighbour mine counter
package gnmc_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
    localparam int WIDTH_REG_W  = 7;
    localparam int HEIGHT_REG_W = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int COUNT_W      = 4;

    localparam logic [7:0] MINE_BYTE = 8'd42;
    localparam logic [7:0] SKIP_BYTE = 8'd10;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [0:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_idx;

    // one line store entry: the cell two rows up and the cell one row up
    typedef struct packed {
        logic above;
        logic middle;
    } t_line_word;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        t_line_word          wdata;
        logic [ADDR_W-1:0]   raddr_a;
        logic [ADDR_W-1:0]   raddr_b;
    } t_mem_req;

    typedef struct packed {
        logic               is_mine;
        logic [COUNT_W-1:0] neighbour_count;
        logic               end_of_row;
        logic               end_of_frame;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

@@ src/gnmc_if.sv @@
`timescale 1ns / 1ps
// request channels for cell bytes in and cell results out
interface gnmc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_byte;
    logic       flush;

    modport source (output valid, output cell_byte, output flush, input ready);
    modport sink   (input valid, input cell_byte, input flush, output ready);
endinterface

interface gnmc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         is_mine;
    logic [gnmc_pkg::COUNT_W-1:0] neighbour_count;
    logic                         end_of_row;
    logic                         end_of_frame;

    modport source (output valid, output is_mine, output neighbour_count,
                    output end_of_row, output end_of_frame, input ready);
    modport sink   (input valid, input is_mine, input neighbour_count,
                    input end_of_row, input end_of_frame, output ready);
endinterface

@@ src/gnmc_line_mem.sv @@
`timescale 1ns / 1ps
// line store ram: two registered read ports, one write port, per-entry valid bits
module gnmc_line_mem (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  gnmc_pkg::t_mem_req     i_req,
    output gnmc_pkg::t_line_word   o_rd_a,
    output gnmc_pkg::t_line_word   o_rd_b
);

    gnmc_pkg::t_line_word r_mem [gnmc_pkg::MAX_WIDTH];
    logic [gnmc_pkg::MAX_WIDTH-1:0] r_vld;
    gnmc_pkg::t_line_word r_rd_a;
    gnmc_pkg::t_line_word r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end
    end

    // write-first: a read of the entry being written sees the new word
    always_ff @(posedge i_clk) begin
        if (i_req.we && i_req.waddr == i_req.raddr_a) begin
            r_rd_a <= i_req.wdata;
        end else if (r_vld[i_req.raddr_a]) begin
            r_rd_a <= r_mem[i_req.raddr_a];
        end else begin
            r_rd_a <= '0;
        end
        if (i_req.we && i_req.waddr == i_req.raddr_b) begin
            r_rd_b <= i_req.wdata;
        end else if (r_vld[i_req.raddr_b]) begin
            r_rd_b <= r_mem[i_req.raddr_b];
        end else begin
            r_rd_b <= '0;
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

@@ src/gnmc_result_fifo.sv @@
`timescale 1ns / 1ps
// result queue: takes up to two results a cycle, hands out one
module gnmc_result_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gnmc_pkg::t_push                     i_push,
    output logic [gnmc_pkg::FIFO_CNT_W-1:0]     o_count,
    gnmc_out_if.source                          o_res
);

    gnmc_pkg::t_result r_mem [gnmc_pkg::FIFO_DEPTH];
    logic [gnmc_pkg::FIFO_AW-1:0]    r_head;
    logic [gnmc_pkg::FIFO_AW-1:0]    r_tail;
    logic [gnmc_pkg::FIFO_CNT_W-1:0] r_count;
    logic [gnmc_pkg::FIFO_AW-1:0]    n_tail1;
    logic                            pop;
    gnmc_pkg::t_result               head_data;

    assign pop       = o_res.valid && o_res.ready;
    assign n_tail1   = r_tail + gnmc_pkg::FIFO_AW'(1);
    assign head_data = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_tail] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[n_tail1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + gnmc_pkg::FIFO_AW'(i_push.n);
            r_head  <= r_head + gnmc_pkg::FIFO_AW'(pop);
            r_count <= r_count + gnmc_pkg::FIFO_CNT_W'(i_push.n)
                       - gnmc_pkg::FIFO_CNT_W'(pop);
        end
    end

    assign o_count               = r_count;
    assign o_res.valid           = r_count != '0;
    assign o_res.is_mine         = head_data.is_mine;
    assign o_res.neighbour_count = head_data.neighbour_count;
    assign o_res.end_of_row      = head_data.end_of_row;
    assign o_res.end_of_frame    = head_data.end_of_frame;

endmodule

@@ src/gnmc_scan.sv @@
`timescale 1ns / 1ps
// scan control: position tracking, line store access and 3x3 window counting
module gnmc_scan (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [gnmc_pkg::WIDTH_REG_W-1:0]      i_width,
    input  logic [gnmc_pkg::ROW_W-1:0]            i_height,
    input  logic [gnmc_pkg::FIFO_CNT_W-1:0]       i_fifo_count,
    input  gnmc_pkg::t_line_word                  i_rd_a,
    input  gnmc_pkg::t_line_word                  i_rd_b,
    output gnmc_pkg::t_mem_req                    o_mem,
    output gnmc_pkg::t_push                       o_push,
    gnmc_in_if.sink                               i_cell
);

    typedef struct packed {
        logic                        valid;
        logic                        flush;
        logic                        mine;
        logic [gnmc_pkg::ADDR_W-1:0] addr;
        logic                        row_ge1;
        logic                        row_ge2;
        logic                        col_ge1;
        logic                        last;
        logic [1:0]                  nres;
    } t_s1;

    function automatic logic [gnmc_pkg::COUNT_W-1:0] ones9(input logic [8:0] v);
        logic [gnmc_pkg::COUNT_W-1:0] n;
        n = '0;
        for (int k = 0; k < 9; k++) begin
            n = n + gnmc_pkg::COUNT_W'(v[k]);
        end
        return n;
    endfunction

    function automatic gnmc_pkg::t_result window_result(input logic [8:0] w,
                                                        input logic eor);
        gnmc_pkg::t_result r;
        r.is_mine         = w[4];
        r.neighbour_count = w[4] ? '0 : ones9(w & 9'h1EF);
        r.end_of_row      = eor;
        r.end_of_frame    = 1'b0;
        return r;
    endfunction

    logic [gnmc_pkg::ADDR_W-1:0] r_col, n_col;
    logic [gnmc_pkg::ROW_W-1:0]  r_row, n_row;
    logic [gnmc_pkg::ADDR_W-1:0] r_fpos, n_fpos;
    t_s1                         r_s1, n_s1;
    logic [8:0]                  r_win;
    gnmc_pkg::t_line_word        r_prev;

    logic pending, accept, cell_ok, flush_ok;
    logic col_last, fpos_last, row_ge1, row_ge2;
    logic [gnmc_pkg::FIFO_CNT_W:0] room_need;

    // stage 1 signals
    logic       up, mid;
    logic [2:0] col3;
    logic [8:0] win, win_sh;
    gnmc_pkg::t_result res_a, res_b, res_f;
    logic [gnmc_pkg::COUNT_W-1:0] fcnt;

    assign pending   = r_row >= i_height;
    assign cell_ok   = !i_cell.flush && i_cell.cell_byte != gnmc_pkg::SKIP_BYTE && !pending;
    assign flush_ok  = i_cell.flush && pending;
    assign col_last  = ({1'b0, r_col} + 7'd1) >= i_width;
    assign fpos_last = ({1'b0, r_fpos} + 7'd1) >= i_width;
    assign row_ge1   = r_row != '0;
    assign row_ge2   = r_row >= gnmc_pkg::ROW_W'(2);

    // worst case: stage 1 results plus two for the new request must fit in the queue
    assign room_need = {1'b0, i_fifo_count} + (gnmc_pkg::FIFO_CNT_W + 1)'(r_s1.nres)
                       + (gnmc_pkg::FIFO_CNT_W + 1)'(2);
    assign i_cell.ready = room_need <= (gnmc_pkg::FIFO_CNT_W + 1)'(gnmc_pkg::FIFO_DEPTH);
    assign accept = i_cell.valid && i_cell.ready;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_fpos = r_fpos;
        n_s1   = '0;
        if (accept) begin
            priority if (flush_ok) begin
                n_s1.valid   = 1'b1;
                n_s1.flush   = 1'b1;
                n_s1.addr    = r_fpos;
                n_s1.col_ge1 = r_fpos != '0;
                n_s1.last    = fpos_last;
                n_s1.nres    = 2'd1;
                if (fpos_last) begin
                    n_row  = '0;
                    n_col  = '0;
                    n_fpos = '0;
                end else begin
                    n_fpos = r_fpos + gnmc_pkg::ADDR_W'(1);
                end
            end else if (cell_ok) begin
                n_s1.valid   = 1'b1;
                n_s1.mine    = i_cell.cell_byte == gnmc_pkg::MINE_BYTE;
                n_s1.addr    = r_col;
                n_s1.row_ge1 = row_ge1;
                n_s1.row_ge2 = row_ge2;
                n_s1.col_ge1 = r_col != '0;
                n_s1.last    = col_last;
                n_s1.nres    = 2'(row_ge1 && r_col != '0) + 2'(row_ge1 && col_last);
                if (col_last) begin
                    n_col  = '0;
                    n_row  = r_row + gnmc_pkg::ROW_W'(1);
                    n_fpos = '0;
                end else begin
                    n_col = r_col + gnmc_pkg::ADDR_W'(1);
                end
            end else begin
                n_s1 = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_fpos <= '0;
            r_s1   <= '0;
            r_win  <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_fpos <= n_fpos;
            r_s1   <= n_s1;
            if (r_s1.valid) begin
                if (r_s1.flush) begin
                    if (r_s1.last) begin
                        r_win <= '0;
                    end
                end else begin
                    r_win <= r_s1.last ? win_sh : win;
                end
            end
        end
    end

    // entry left of the flush position; a cell written there keeps it current
    always_ff @(posedge i_clk) begin
        if (r_s1.valid && r_s1.flush) begin
            r_prev <= i_rd_a;
        end else if (o_mem.we && o_mem.waddr == r_fpos - gnmc_pkg::ADDR_W'(1)) begin
            r_prev <= o_mem.wdata;
        end
    end

    // read both ports every cycle; data matters only for an accepted request
    always_comb begin
        o_mem.raddr_a      = i_cell.flush ? r_fpos : r_col;
        o_mem.raddr_b      = r_fpos + gnmc_pkg::ADDR_W'(1);
        o_mem.we           = r_s1.valid && !r_s1.flush;
        o_mem.waddr        = r_s1.addr;
        o_mem.wdata.above  = mid;
        o_mem.wdata.middle = r_s1.mine;
    end

    // window columns: bit 0 top, bit 1 middle, bit 2 bottom; oldest column lowest
    assign up     = r_s1.row_ge2 & i_rd_a.above;
    assign mid    = r_s1.row_ge1 & i_rd_a.middle;
    assign col3   = {r_s1.mine, mid, up};
    assign win    = r_s1.col_ge1 ? {col3, r_win[8:3]} : {col3, 6'b0};
    assign win_sh = {3'b0, win[8:3]};
    assign res_a  = window_result(win, 1'b0);
    assign res_b  = window_result(win_sh, 1'b1);

    assign fcnt = gnmc_pkg::COUNT_W'(i_rd_a.above)
                  + (r_s1.col_ge1 ? gnmc_pkg::COUNT_W'(r_prev.above)
                                    + gnmc_pkg::COUNT_W'(r_prev.middle) : '0)
                  + (!r_s1.last ? gnmc_pkg::COUNT_W'(i_rd_b.above)
                                  + gnmc_pkg::COUNT_W'(i_rd_b.middle) : '0);

    always_comb begin
        res_f.is_mine         = i_rd_a.middle;
        res_f.neighbour_count = i_rd_a.middle ? '0 : fcnt;
        res_f.end_of_row      = r_s1.last;
        res_f.end_of_frame    = r_s1.last;
    end

    always_comb begin
        o_push.n  = r_s1.valid ? r_s1.nres : 2'd0;
        o_push.r1 = res_b;
        if (r_s1.flush) begin
            o_push.r0 = res_f;
        end else if (r_s1.row_ge1 && r_s1.col_ge1) begin
            o_push.r0 = res_a;
        end else begin
            o_push.r0 = res_b;
        end
    end

endmodule

@@ src/grid_neighbour_mine_count_top.sv @@
`timescale 1ns / 1ps
// results: a result is pushed in the cycle after the request that completes it and is
//   offered on o_res the cycle after that, once the result queue holds it
// throughput: one request per cycle, set by the single line store read and write
//   per cell; i_cell.ready drops only when the 8-entry result queue could overflow
// reset (synchronous, active low): clears positions, window, queue and the line store
//   valid bits at once; grid_width returns to 64, grid_height to 1024; no clearing pass
module grid_neighbour_mine_count_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_idx,
    input  logic [gnmc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    gnmc_in_if.sink                             i_cell,
    gnmc_out_if.source                          o_res
);

    logic [gnmc_pkg::WIDTH_REG_W-1:0]  r_grid_width;
    logic [gnmc_pkg::HEIGHT_REG_W-1:0] r_grid_height;
    logic [gnmc_pkg::WIDTH_REG_W-1:0]  width_used;
    logic [gnmc_pkg::ROW_W-1:0]        height_used;
    logic [gnmc_pkg::FIFO_CNT_W-1:0]   fifo_count;
    gnmc_pkg::t_mem_req                mem_req;
    gnmc_pkg::t_line_word              rd_a, rd_b;
    gnmc_pkg::t_push                   push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= gnmc_pkg::WIDTH_REG_W'(gnmc_pkg::MAX_WIDTH);
            r_grid_height <= gnmc_pkg::HEIGHT_REG_W'(gnmc_pkg::MAX_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (gnmc_pkg::t_cfg_idx'(i_cfg_idx))
                gnmc_pkg::CFG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data[gnmc_pkg::WIDTH_REG_W-1:0];
                end
                gnmc_pkg::CFG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_data[gnmc_pkg::HEIGHT_REG_W-1:0];
                end
            endcase
        end
    end

    // clamp to 1..max
    always_comb begin
        if (r_grid_width == '0) begin
            width_used = gnmc_pkg::WIDTH_REG_W'(1);
        end else if (r_grid_width > gnmc_pkg::WIDTH_REG_W'(gnmc_pkg::MAX_WIDTH)) begin
            width_used = gnmc_pkg::WIDTH_REG_W'(gnmc_pkg::MAX_WIDTH);
        end else begin
            width_used = r_grid_width;
        end
        if (r_grid_height == '0) begin
            height_used = gnmc_pkg::ROW_W'(1);
        end else if (r_grid_height > gnmc_pkg::HEIGHT_REG_W'(gnmc_pkg::MAX_HEIGHT)) begin
            height_used = gnmc_pkg::ROW_W'(gnmc_pkg::MAX_HEIGHT);
        end else begin
            height_used = gnmc_pkg::ROW_W'(r_grid_height);
        end
    end

    gnmc_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_width      (width_used),
        .i_height     (height_used),
        .i_fifo_count (fifo_count),
        .i_rd_a       (rd_a),
        .i_rd_b       (rd_b),
        .o_mem        (mem_req),
        .o_push       (push),
        .i_cell       (i_cell)
    );

    gnmc_line_mem u_line_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rd_a  (rd_a),
        .o_rd_b  (rd_b)
    );

    gnmc_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (fifo_count),
        .o_res   (o_res)
    );

endmodule

@@ src/gnmc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks on the result channel, bound to the top level
module gnmc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic                         i_is_mine,
    input logic [gnmc_pkg::COUNT_W-1:0] i_count,
    input logic                         i_eor,
    input logic                         i_eof
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result request dropped while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_count <= gnmc_pkg::COUNT_W'(8))
        else $error("neighbour count above eight");

    a_mine_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_is_mine |-> i_count == '0)
        else $error("mine cell with nonzero count");

    a_eof_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_eof |-> i_eor)
        else $error("end of frame without end of row");

endmodule

bind grid_neighbour_mine_count_top gnmc_checker u_gnmc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_res.valid),
    .i_ready   (o_res.ready),
    .i_is_mine (o_res.is_mine),
    .i_count   (o_res.neighbour_count),
    .i_eor     (o_res.end_of_row),
    .i_eof     (o_res.end_of_frame)
);
